/* rtl/multi_voice_sample_mixer_top_defines.svh */
// assertion macros for the multi-voice sample mixer
`ifndef MULTI_VOICE_SAMPLE_MIXER_TOP_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MVSM_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MVSM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mvsm_pkg.sv */
// shared types and constants of the multi-voice sample mixer
package mvsm_pkg;

   localparam int VOICE_COUNT_DEF  = 48;
   // sample memory depth, a power of two
   localparam int SAMPLE_WORDS_DEF = 65536;

   localparam int ACTION_W  = 2;
   localparam int ADDR_IN_W = 16;
   localparam int SAMPLE_W  = 16;
   localparam int VIDX_W    = 6;
   localparam int LEN_W     = 17;
   localparam int GAIN_W    = 16;
   localparam int OUT_W     = 24;
   localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
   localparam int TERM_W    = 18;

   localparam int FRAC_BITS  = 15;
   localparam int ROUND_HALF = 16384;
   localparam int OUT_MAX    = 8388607;
   localparam int OUT_MIN    = -8388608;

   localparam logic [GAIN_W-1:0] MASTER_GAIN_RESET = 16'd32768;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_MIX   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              loop;
      logic [GAIN_W-1:0] gain;
      logic [15:0]       base;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  pos;
   } voice_rec_type;

   typedef struct packed {
      logic clear;
      logic term_valid;
      logic scale;
   } acc_ctl_type;

endpackage

/* rtl/mvsm_if.sv */
// item channels of the multi-voice sample mixer
interface mvsm_req_if;
   logic                                valid;
   logic                                ready;
   logic        [mvsm_pkg::ACTION_W-1:0]  action;
   logic        [mvsm_pkg::ADDR_IN_W-1:0] sample_address;
   logic signed [mvsm_pkg::SAMPLE_W-1:0]  sample_value;
   logic        [mvsm_pkg::VIDX_W-1:0]    voice_index;
   logic        [15:0]                    clip_base;
   logic        [mvsm_pkg::LEN_W-1:0]     clip_size;
   logic        [mvsm_pkg::GAIN_W-1:0]    volume_in;
   logic                                  loop_enable;

   modport source (
      output valid, action, sample_address, sample_value, voice_index,
             clip_base, clip_size, volume_in, loop_enable,
      input  ready
   );
   modport sink (
      input  valid, action, sample_address, sample_value, voice_index,
             clip_base, clip_size, volume_in, loop_enable,
      output ready
   );
endinterface

interface mvsm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mvsm_pkg::OUT_W-1:0] mixed_sample;

   modport source (output valid, mixed_sample, input ready);
   modport sink (input valid, mixed_sample, output ready);
endinterface

/* rtl/mvsm_sample_mem.sv */
// shared sample memory, one write and one registered read port
module mvsm_sample_mem #(
   parameter int SAMPLE_WORDS = mvsm_pkg::SAMPLE_WORDS_DEF,
   localparam int AW = $clog2(SAMPLE_WORDS)
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [mvsm_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                 rd_en,
   input  logic [AW-1:0]                        rd_addr,
   output logic signed [mvsm_pkg::SAMPLE_W-1:0] rd_data
);

   logic signed [mvsm_pkg::SAMPLE_W-1:0] sample_mem_ff [SAMPLE_WORDS];
   logic signed [mvsm_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sample_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mvsm_voice_mem.sv */
// per-voice record memory, one write and one registered read port
module mvsm_voice_mem #(
   parameter int VOICE_COUNT = mvsm_pkg::VOICE_COUNT_DEF,
   localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [VI_W-1:0]         wr_addr,
   input  mvsm_pkg::voice_rec_type wr_data,
   input  logic                    rd_en,
   input  logic [VI_W-1:0]         rd_addr,
   output mvsm_pkg::voice_rec_type rd_data
);

   mvsm_pkg::voice_rec_type voice_mem_ff [VOICE_COUNT];
   mvsm_pkg::voice_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         voice_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= voice_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mvsm_mix_acc.sv */
// voice gain multiply, frame accumulation and master scaling
module mvsm_mix_acc #(
   parameter int VOICE_COUNT = mvsm_pkg::VOICE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mvsm_pkg::acc_ctl_type                ctl,
   input  logic signed [mvsm_pkg::SAMPLE_W-1:0] sample,
   input  logic [mvsm_pkg::GAIN_W-1:0]          gain,
   input  logic [mvsm_pkg::GAIN_W-1:0]          master_gain,
   output logic                                 busy,
   output logic signed [mvsm_pkg::OUT_W-1:0]    mixed
);

   localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int SUM_W = mvsm_pkg::TERM_W + VI_W;
   localparam int SCL_W = SUM_W + mvsm_pkg::GAIN_W + 1;
   localparam int RND_W = SCL_W + 1;
   localparam int PRD_W = mvsm_pkg::PROD_W;

   logic signed [PRD_W-1:0]            prd_in, prd_ff;
   logic                               prd_vld_in, prd_vld_ff;
   logic signed [PRD_W:0]              prd_rnd, prd_shf;
   logic signed [mvsm_pkg::TERM_W-1:0] term;
   logic signed [SUM_W-1:0]            sum_in, sum_ff;
   logic signed [SCL_W-1:0]            scl_in, scl_ff;
   logic signed [RND_W-1:0]            rnd_add, rnd_shf;

   assign prd_in     = sample * $signed({1'b0, gain});
   assign prd_vld_in = ctl.term_valid;

   assign prd_rnd = (PRD_W + 1)'(prd_ff) + (PRD_W + 1)'(mvsm_pkg::ROUND_HALF);
   assign prd_shf = prd_rnd >>> mvsm_pkg::FRAC_BITS;
   assign term    = $signed(prd_shf[mvsm_pkg::TERM_W-1:0]);

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (prd_vld_ff) begin
         sum_in = sum_ff + SUM_W'(term);
      end
   end

   assign scl_in = sum_ff * $signed({1'b0, master_gain});

   assign rnd_add = RND_W'(scl_ff) + RND_W'(mvsm_pkg::ROUND_HALF);
   assign rnd_shf = rnd_add >>> mvsm_pkg::FRAC_BITS;

   always_comb begin
      if (rnd_shf > RND_W'(mvsm_pkg::OUT_MAX)) begin
         mixed = mvsm_pkg::OUT_W'(mvsm_pkg::OUT_MAX);
      end else if (rnd_shf < RND_W'(mvsm_pkg::OUT_MIN)) begin
         mixed = mvsm_pkg::OUT_W'(mvsm_pkg::OUT_MIN);
      end else begin
         mixed = $signed(rnd_shf[mvsm_pkg::OUT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_vld_ff <= 1'b0;
      end else begin
         prd_vld_ff <= prd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prd_ff <= prd_in;
      sum_ff <= sum_in;
      if (ctl.scale) begin
         scl_ff <= scl_in;
      end
   end

   assign busy = prd_vld_ff;

endmodule

/* rtl/multi_voice_sample_mixer_top.sv */
// top level of the multi-voice sample mixer
//
//  channel   dir  payload                                   handshake
//  req_chan  in   action, sample/voice/clip fields          valid/ready
//  rsp_chan  out  mixed_sample                              valid/ready
//  csr       in   master_gain                               csr_wr_en
//
// sample write, voice start and voice stop are taken back to back while idle
// a frame reads one voice per cycle, then drains the read, sample and product
// registers, scales the sum by the master gain and registers the result
// the next item can be taken in the cycle after the result is registered
// reset clears the voice active flags at once; the sample memory is not cleared
// a stalled rsp_chan holds its item; a following frame waits for the output register
`include "multi_voice_sample_mixer_top_defines.svh"
module multi_voice_sample_mixer_top #(
   parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
   parameter int SAMPLE_WORDS = mvsm_pkg::SAMPLE_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mvsm_req_if.sink                      req_chan,
   mvsm_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [mvsm_pkg::GAIN_W-1:0]   csr_wr_data
);

   localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int AW   = $clog2(SAMPLE_WORDS);
   localparam int WA_W = (AW > mvsm_pkg::ADDR_IN_W) ? AW : mvsm_pkg::ADDR_IN_W;
   localparam int RA_W = (AW > mvsm_pkg::LEN_W + 1) ? AW : mvsm_pkg::LEN_W + 1;
   localparam logic [VI_W-1:0] LAST = VI_W'(VOICE_COUNT - 1);

   mvsm_pkg::state_type state_in, state_ff;
   logic [VI_W-1:0]                    voice_cnt_in, voice_cnt_ff;
   logic [VOICE_COUNT-1:0]             active_in, active_ff;
   logic                               rd_vld_in, rd_vld_ff;
   logic [VI_W-1:0]                    rd_idx_in, rd_idx_ff;
   logic                               smp_vld_in, smp_vld_ff;
   logic [mvsm_pkg::GAIN_W-1:0]        gain_in, gain_ff;
   logic [mvsm_pkg::GAIN_W-1:0]        master_gain_in, master_gain_ff;
   logic                               rsp_valid_in, rsp_valid_ff;
   logic signed [mvsm_pkg::OUT_W-1:0]  rsp_data_in, rsp_data_ff;

   mvsm_pkg::action_type    act;
   mvsm_pkg::voice_rec_type rec, vmem_wr_data, start_rec, wb_rec;
   mvsm_pkg::voice_rec_type vmem_rd_data_w;
   mvsm_pkg::acc_ctl_type   acc_ctl;
   logic                    req_accept, vidx_ok, mix_go;
   logic [VI_W-1:0]         vidx;
   logic                    vmem_start_wr, vmem_wb, vmem_wr_en, vmem_rd_en;
   logic [VI_W-1:0]         vmem_wr_addr;
   logic                    stop_wr, smp_wr;
   logic [WA_W-1:0]         smp_wr_ext;
   logic                    wrap, cur_act, kill;
   logic [mvsm_pkg::LEN_W-1:0] pos_eff;
   logic [RA_W-1:0]         smp_rd_ext;
   logic signed [mvsm_pkg::SAMPLE_W-1:0] smp_rd_data;
   logic                    acc_busy, out_free, emit;
   logic signed [mvsm_pkg::OUT_W-1:0] mixed;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign act        = mvsm_pkg::action_type'(req_chan.action);
   assign vidx_ok    = req_chan.voice_index < VOICE_COUNT;
   assign vidx       = req_chan.voice_index[VI_W-1:0];
   assign mix_go     = req_accept && (act == mvsm_pkg::ACT_MIX);

   assign smp_wr        = req_accept && (act == mvsm_pkg::ACT_WRITE);
   assign vmem_start_wr = req_accept && (act == mvsm_pkg::ACT_START) && vidx_ok;
   assign stop_wr       = req_accept && (act == mvsm_pkg::ACT_STOP) && vidx_ok;
   assign smp_wr_ext    = WA_W'(req_chan.sample_address);

   // voice record out of the memory
   assign rec     = vmem_rd_data_w;
   assign wrap    = rec.pos >= rec.length;
   assign pos_eff = wrap ? '0 : rec.pos;
   assign cur_act = active_ff[rd_idx_ff];
   assign vmem_wb = rd_vld_ff && cur_act && (!wrap || rec.loop);
   assign kill    = rd_vld_ff && cur_act && wrap && !rec.loop;
   assign smp_rd_ext = RA_W'(rec.base) + RA_W'(pos_eff);

   always_comb begin
      start_rec        = '0;
      start_rec.loop   = req_chan.loop_enable;
      start_rec.gain   = req_chan.volume_in;
      start_rec.base   = req_chan.clip_base;
      start_rec.length = req_chan.clip_size;
      wb_rec           = rec;
      wb_rec.pos       = pos_eff + 1'b1;
   end

   assign vmem_wr_en   = vmem_start_wr || vmem_wb;
   assign vmem_wr_addr = vmem_start_wr ? vidx : rd_idx_ff;
   assign vmem_wr_data = vmem_start_wr ? start_rec : wb_rec;

   always_comb begin
      active_in = active_ff;
      if (vmem_start_wr) begin
         active_in[vidx] = req_chan.clip_size != '0;
      end
      if (stop_wr) begin
         active_in[vidx] = 1'b0;
      end
      if (kill) begin
         active_in[rd_idx_ff] = 1'b0;
      end
   end

   assign rd_vld_in  = vmem_rd_en;
   assign rd_idx_in  = voice_cnt_ff;
   assign smp_vld_in = vmem_wb;
   assign gain_in    = rec.gain;

   assign master_gain_in = csr_wr_en ? csr_wr_data : master_gain_ff;

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = emit ? mixed : rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mvsm_pkg::ST_IDLE: begin
            if (mix_go) state_in = mvsm_pkg::ST_RUN;
         end
         mvsm_pkg::ST_RUN: begin
            if (voice_cnt_ff == LAST) state_in = mvsm_pkg::ST_DRAIN;
         end
         mvsm_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !smp_vld_ff && !acc_busy) state_in = mvsm_pkg::ST_SCALE;
         end
         mvsm_pkg::ST_SCALE: begin
            state_in = mvsm_pkg::ST_EMIT;
         end
         mvsm_pkg::ST_EMIT: begin
            if (out_free) state_in = mvsm_pkg::ST_IDLE;
         end
         default: begin
            state_in = mvsm_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready     = 1'b0;
      vmem_rd_en         = 1'b0;
      voice_cnt_in       = voice_cnt_ff;
      emit               = 1'b0;
      acc_ctl.clear      = mix_go;
      acc_ctl.term_valid = smp_vld_ff;
      acc_ctl.scale      = 1'b0;
      unique case (state_ff)
         mvsm_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            voice_cnt_in   = '0;
         end
         mvsm_pkg::ST_RUN: begin
            vmem_rd_en   = 1'b1;
            voice_cnt_in = voice_cnt_ff + 1'b1;
         end
         mvsm_pkg::ST_DRAIN: begin
         end
         mvsm_pkg::ST_SCALE: begin
            acc_ctl.scale = 1'b1;
         end
         mvsm_pkg::ST_EMIT: begin
            emit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mvsm_pkg::ST_IDLE;
         voice_cnt_ff   <= '0;
         active_ff      <= '0;
         rd_vld_ff      <= 1'b0;
         smp_vld_ff     <= 1'b0;
         master_gain_ff <= mvsm_pkg::MASTER_GAIN_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         voice_cnt_ff   <= voice_cnt_in;
         active_ff      <= active_in;
         rd_vld_ff      <= rd_vld_in;
         smp_vld_ff     <= smp_vld_in;
         master_gain_ff <= master_gain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      gain_ff     <= gain_in;
      rsp_data_ff <= rsp_data_in;
   end

   mvsm_voice_mem #(
      .VOICE_COUNT (VOICE_COUNT)
   ) u_voice_mem (
      .clock   (clock),
      .wr_en   (vmem_wr_en),
      .wr_addr (vmem_wr_addr),
      .wr_data (vmem_wr_data),
      .rd_en   (vmem_rd_en),
      .rd_addr (voice_cnt_ff),
      .rd_data (vmem_rd_data_w)
   );

   mvsm_sample_mem #(
      .SAMPLE_WORDS (SAMPLE_WORDS)
   ) u_sample_mem (
      .clock   (clock),
      .wr_en   (smp_wr),
      .wr_addr (smp_wr_ext[AW-1:0]),
      .wr_data (req_chan.sample_value),
      .rd_en   (vmem_wb),
      .rd_addr (smp_rd_ext[AW-1:0]),
      .rd_data (smp_rd_data)
   );

   mvsm_mix_acc #(
      .VOICE_COUNT (VOICE_COUNT)
   ) u_mix_acc (
      .clock       (clock),
      .reset       (reset),
      .ctl         (acc_ctl),
      .sample      (smp_rd_data),
      .gain        (gain_ff),
      .master_gain (master_gain_ff),
      .busy        (acc_busy),
      .mixed       (mixed)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mixed_sample = rsp_data_ff;

   `MVSM_ASSERT_IMPL(a_one_voice_write, vmem_start_wr, !vmem_wb, "start and writeback collide")
   `MVSM_ASSERT_IMPL(a_drained_before_scale, state_ff == mvsm_pkg::ST_SCALE, !rd_vld_ff && !smp_vld_ff && !acc_busy, "frame scaled before pipeline drained")
   `MVSM_ASSERT_IMPL(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff == mvsm_pkg::ST_EMIT), "item shown outside emit")
   `MVSM_ASSERT_NEXT(a_frame_starts_at_zero, mix_go, state_ff == mvsm_pkg::ST_RUN && voice_cnt_ff == '0, "frame did not start at voice zero")

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the multi-voice sample mixer, directed and random items
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VOICES         = mvsm_pkg::VOICE_COUNT_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int POOL_LOW       = 65504;
   localparam int POOL_SPAN      = 128;
   localparam int DIRECTED_ITEMS = 25;
   localparam int PHASE_ITEMS    = 113;
   localparam int PHASE_COUNT    = 6;

   typedef struct {
      mvsm_pkg::action_type                 action;
      logic [mvsm_pkg::ADDR_IN_W-1:0]       addr;
      logic signed [mvsm_pkg::SAMPLE_W-1:0] value;
      logic [mvsm_pkg::VIDX_W-1:0]          voice;
      logic [15:0]                          base;
      logic [mvsm_pkg::LEN_W-1:0]           size;
      logic [mvsm_pkg::GAIN_W-1:0]          vol;
      logic                                 loop_en;
   } mixer_item_type;

   class mixer_scoreboard;
      logic signed [mvsm_pkg::SAMPLE_W-1:0] sample_mem [mvsm_pkg::SAMPLE_WORDS_DEF];
      bit                                   word_written [mvsm_pkg::SAMPLE_WORDS_DEF];
      bit                                   voice_on [VOICES];
      bit                                   voice_rewind [VOICES];
      logic [mvsm_pkg::GAIN_W-1:0]          voice_vol [VOICES];
      logic [15:0]                          voice_base [VOICES];
      logic [mvsm_pkg::LEN_W-1:0]           voice_len [VOICES];
      logic [mvsm_pkg::LEN_W-1:0]           voice_pos [VOICES];
      logic [mvsm_pkg::GAIN_W-1:0]          master_gain;
      logic signed [mvsm_pkg::OUT_W-1:0]    expected_frames [$];
      int                                   error_count;
      int                                   frames_checked;

      function new();
         master_gain = mvsm_pkg::MASTER_GAIN_RESET;
         error_count = 0;
         frames_checked = 0;
         for (int v = 0; v < VOICES; v++) begin
            voice_on[v] = 1'b0;
            voice_rewind[v] = 1'b0;
            voice_vol[v] = '0;
            voice_base[v] = '0;
            voice_len[v] = '0;
            voice_pos[v] = '0;
         end
      endfunction

      function logic signed [mvsm_pkg::OUT_W-1:0] mix_next_frame();
         longint      sum;
         longint      term;
         longint      scaled;
         logic [15:0] addr;
         sum = 0;
         for (int v = 0; v < VOICES; v++) begin
            if (!voice_on[v] || voice_len[v] == 0) continue;
            if (voice_pos[v] >= voice_len[v]) begin
               if (voice_rewind[v]) begin
                  voice_pos[v] = '0;
               end else begin
                  voice_on[v] = 1'b0;
                  continue;
               end
            end
            addr = voice_base[v] + voice_pos[v][15:0];
            term = longint'(sample_mem[addr]) * longint'(voice_vol[v]);
            sum += (term + mvsm_pkg::ROUND_HALF) >>> mvsm_pkg::FRAC_BITS;
            voice_pos[v] = voice_pos[v] + 1'b1;
         end
         scaled = (sum * longint'(master_gain) + mvsm_pkg::ROUND_HALF) >>> mvsm_pkg::FRAC_BITS;
         if (scaled > mvsm_pkg::OUT_MAX) scaled = mvsm_pkg::OUT_MAX;
         if (scaled < mvsm_pkg::OUT_MIN) scaled = mvsm_pkg::OUT_MIN;
         return mvsm_pkg::OUT_W'(scaled);
      endfunction

      // first sample word the next frame would read before anything wrote it
      function bit find_unwritten_read(output logic [15:0] addr);
         logic [15:0] a;
         addr = '0;
         for (int v = 0; v < VOICES; v++) begin
            if (!voice_on[v] || voice_len[v] == 0) continue;
            if (voice_pos[v] < voice_len[v]) begin
               a = voice_base[v] + voice_pos[v][15:0];
            end else if (voice_rewind[v]) begin
               a = voice_base[v];
            end else begin
               continue;
            end
            if (!word_written[a]) begin
               addr = a;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_item(mixer_item_type it);
         case (it.action)
            mvsm_pkg::ACT_WRITE: begin
               sample_mem[it.addr] = it.value;
               word_written[it.addr] = 1'b1;
            end
            mvsm_pkg::ACT_START: begin
               if (it.voice < VOICES) begin
                  voice_base[it.voice] = it.base;
                  voice_len[it.voice] = it.size;
                  voice_vol[it.voice] = it.vol;
                  voice_rewind[it.voice] = it.loop_en;
                  voice_pos[it.voice] = '0;
                  voice_on[it.voice] = (it.size != 0);
               end
            end
            mvsm_pkg::ACT_STOP: begin
               if (it.voice < VOICES) voice_on[it.voice] = 1'b0;
            end
            default: begin
               expected_frames.push_back(mix_next_frame());
            end
         endcase
      endfunction

      function void check_frame(logic signed [mvsm_pkg::OUT_W-1:0] got);
         logic signed [mvsm_pkg::OUT_W-1:0] want;
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected frame, expected none, actual %0d", $time, got);
            error_count++;
         end else begin
            want = expected_frames.pop_front();
            frames_checked++;
            if (got !== want) begin
               $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                        $time, want, got);
               error_count++;
            end
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [mvsm_pkg::GAIN_W-1:0] csr_wr_data;
   int                          send_idle_pct;
   int                          recv_idle_pct;
   int                          stall_cycles;
   int                          items_sent;
   mixer_scoreboard             mixer_sb;

   mvsm_req_if req_bus ();
   mvsm_rsp_if rsp_bus ();

   multi_voice_sample_mixer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) mixer_sb.check_frame(rsp_bus.mixed_sample);
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   function automatic mixer_item_type random_item(mvsm_pkg::action_type act);
      mixer_item_type it;
      it.action = act;
      it.addr = mvsm_pkg::ADDR_IN_W'($urandom);
      it.value = mvsm_pkg::SAMPLE_W'($urandom);
      it.voice = mvsm_pkg::VIDX_W'($urandom);
      it.base = 16'($urandom);
      it.size = mvsm_pkg::LEN_W'($urandom_range(0, 65536));
      it.vol = mvsm_pkg::GAIN_W'($urandom);
      it.loop_en = 1'($urandom);
      return it;
   endfunction

   task automatic send_item(input mixer_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= it.action;
      req_bus.sample_address <= it.addr;
      req_bus.sample_value <= it.value;
      req_bus.voice_index <= it.voice;
      req_bus.clip_base <= it.base;
      req_bus.clip_size <= it.size;
      req_bus.volume_in <= it.vol;
      req_bus.loop_enable <= it.loop_en;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mixer_sb.note_item(it);
      items_sent++;
   endtask

   task automatic write_word(input logic [15:0] addr, input logic signed [15:0] value);
      mixer_item_type it;
      it = random_item(mvsm_pkg::ACT_WRITE);
      it.addr = addr;
      it.value = value;
      send_item(it);
   endtask

   task automatic start_voice(input logic [5:0] voice, input logic [15:0] base,
                              input logic [16:0] size, input logic [15:0] vol,
                              input logic loop_en);
      mixer_item_type it;
      it = random_item(mvsm_pkg::ACT_START);
      it.voice = voice;
      it.base = base;
      it.size = size;
      it.vol = vol;
      it.loop_en = loop_en;
      send_item(it);
   endtask

   task automatic stop_voice(input logic [5:0] voice);
      mixer_item_type it;
      it = random_item(mvsm_pkg::ACT_STOP);
      it.voice = voice;
      send_item(it);
   endtask

   // fill any sample word the frame would read that was never written, then send the mix item
   task automatic mix_frame_item();
      logic [15:0] addr;
      while (mixer_sb.find_unwritten_read(addr)) begin
         write_word(addr, mvsm_pkg::SAMPLE_W'($urandom));
      end
      send_item(random_item(mvsm_pkg::ACT_MIX));
   endtask

   task automatic wait_idle();
      while (mixer_sb.expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_master_gain(input logic [mvsm_pkg::GAIN_W-1:0] gain);
      csr_wr_en <= 1'b1;
      csr_wr_data <= gain;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mixer_sb.master_gain = gain;
   endtask

   initial begin : main
      logic [mvsm_pkg::GAIN_W-1:0] gains [PHASE_COUNT];
      logic [15:0]                 a;
      logic signed [15:0]          val;
      logic [5:0]                  vi;
      logic [15:0]                 vol;
      logic [15:0]                 base;
      logic [16:0]                 size;
      int                          pick;

      mixer_sb = new();
      items_sent = 0;
      send_idle_pct = 9;
      recv_idle_pct = 68;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.action <= mvsm_pkg::ACT_WRITE;
      req_bus.sample_address <= '0;
      req_bus.sample_value <= '0;
      req_bus.voice_index <= '0;
      req_bus.clip_base <= '0;
      req_bus.clip_size <= '0;
      req_bus.volume_in <= '0;
      req_bus.loop_enable <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset master gain
      write_word(16'd0, 16'sh7fff);
      write_word(16'hffff, 16'sh8000);
      write_word(16'd1, 16'sh0000);
      start_voice(6'd0, 16'hffff, 17'd2, 16'd32768, 1'b1);
      start_voice(6'd47, 16'd0, 17'd1, 16'hffff, 1'b0);
      start_voice(6'd48, 16'd0, 17'd1, 16'd32768, 1'b1);
      start_voice(6'd63, 16'd1, 17'd3, 16'd32768, 1'b1);
      start_voice(6'd5, 16'd0, 17'd0, 16'd32768, 1'b1);
      mix_frame_item();
      mix_frame_item();
      mix_frame_item();
      stop_voice(6'd63);
      stop_voice(6'd0);
      mix_frame_item();
      start_voice(6'd1, 16'hffff, 17'd65536, 16'd0, 1'b1);
      start_voice(6'd2, 16'd0, 17'd1, 16'hffff, 1'b1);
      mix_frame_item();
      mix_frame_item();
      stop_voice(6'd1);
      stop_voice(6'd2);
      mix_frame_item();

      gains[0] = 16'd32768;
      gains[1] = 16'd0;
      gains[2] = 16'hffff;
      gains[3] = 16'd1;
      gains[4] = mvsm_pkg::GAIN_W'($urandom_range(2, 65534));
      gains[5] = 16'd16384;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 9;
            recv_idle_pct = 68;
         end else if (phase < 4) begin
            send_idle_pct = 68;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         req_bus.valid <= 1'b0;
         wait_idle();
         write_master_gain(gains[phase]);
         while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
            pick = $urandom_range(99);
            vi = ($urandom_range(9) == 0) ? 6'($urandom_range(48, 63))
                                          : 6'($urandom_range(0, VOICES - 1));
            if (pick < 30) begin
               a = ($urandom_range(9) < 7) ? 16'(POOL_LOW + $urandom_range(0, POOL_SPAN - 1))
                                           : 16'($urandom);
               case ($urandom_range(7))
                  0:       val = 16'sh7fff;
                  1:       val = 16'sh8000;
                  default: val = 16'($urandom);
               endcase
               write_word(a, val);
            end else if (pick < 55) begin
               case ($urandom_range(19))
                  0, 1, 2: begin
                     base = 16'($urandom);
                     size = 17'($urandom_range(0, 65536));
                  end
                  3: begin
                     base = 16'($urandom);
                     size = ($urandom_range(1) == 0) ? 17'd65536 : 17'd0;
                  end
                  default: begin
                     base = 16'(POOL_LOW + $urandom_range(0, 63));
                     size = ($urandom_range(15) == 0) ? 17'd0 : 17'($urandom_range(1, 64));
                  end
               endcase
               case ($urandom_range(9))
                  0:       vol = 16'd0;
                  1:       vol = 16'd32768;
                  2:       vol = 16'hffff;
                  3:       vol = 16'($urandom);
                  default: vol = 16'($urandom_range(0, 32768));
               endcase
               start_voice(vi, base, size, vol, 1'($urandom));
            end else if (pick < 68) begin
               stop_voice(vi);
            end else begin
               mix_frame_item();
            end
         end
      end

      req_bus.valid <= 1'b0;
      wait_idle();
      $display("summary: %0d items sent, %0d frames checked, %0d master gain settings",
               items_sent, mixer_sb.frames_checked, PHASE_COUNT + 1);
      if (mixer_sb.error_count == 0 && mixer_sb.expected_frames.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
